>>> rtl/nba_pkg.sv
// Shared types and codes for the node ID bitmap allocator.
`default_nettype none

package nba_pkg;

   localparam int unsigned ID_W     = 8;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned MAP_W    = 64;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned MODE_W   = 2;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEXT   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CTRL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE  = 3'd4;

   // Request fields broadcast to every cell
   typedef struct packed {
      logic [ID_W-1:0] node_id;
      logic [ID_W-1:0] controller_id;
   } cell_req_type;

   // Update operation broadcast to every cell
   typedef struct packed {
      logic clear_all;
      logic set_target;
      logic set_free;
      logic clr_target;
   } cell_op_type;

   // Search flags handed from one cell to the next higher one
   typedef struct packed {
      logic free_seen;
      logic member_seen;
   } cell_chain_type;

   // Per-cell status back to the controller
   typedef struct packed {
      logic bit_next;
      logic taken;
      logic hit_free;
      logic hit_member;
   } cell_stat_type;

endpackage

`default_nettype wire

>>> rtl/nba_cell.sv
// One membership cell: holds the bit of one node ID and its link in the search chain.
`default_nettype none

module nba_cell #(
   parameter int unsigned CELL_ID   = 0,
   parameter int unsigned LOWEST_ID = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nba_pkg::cell_req_type   req,
   input  wire nba_pkg::cell_op_type    op,
   input  wire nba_pkg::cell_chain_type chain_in,
   output nba_pkg::cell_chain_type      chain_out,
   output nba_pkg::cell_stat_type       stat
);

   localparam logic [nba_pkg::ID_W-1:0] MY_ID = nba_pkg::ID_W'(CELL_ID);
   localparam logic IN_LOW_RANGE = (CELL_ID >= LOWEST_ID);

   logic bit_ff;
   logic bit_in;
   logic is_target;
   logic free_ok;
   logic scan_ok;
   logic hit_free;

   assign is_target = (req.node_id == MY_ID);
   assign free_ok   = IN_LOW_RANGE && (req.controller_id != MY_ID);
   assign scan_ok   = (req.node_id <= MY_ID);

   // first free cell above no earlier free one claims the allocation
   assign hit_free = free_ok && !bit_ff && !chain_in.free_seen;

   assign chain_out.free_seen   = chain_in.free_seen   || (free_ok && !bit_ff);
   assign chain_out.member_seen = chain_in.member_seen || (scan_ok && bit_ff);

   always_comb begin
      if (op.clear_all) begin
         bit_in = 1'b0;
      end else if ((op.set_target && is_target) || (op.set_free && hit_free)) begin
         bit_in = 1'b1;
      end else if (op.clr_target && is_target) begin
         bit_in = 1'b0;
      end else begin
         bit_in = bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign stat.bit_next   = bit_in;
   assign stat.taken      = is_target && bit_ff;
   assign stat.hit_free   = hit_free;
   assign stat.hit_member = scan_ok && bit_ff && !chain_in.member_seen;

endmodule

`default_nettype wire

>>> rtl/node_id_bitmap_allocator.sv
// Top level of the node ID bitmap allocator: request control and the row of cells.
`default_nettype none

// Usage
//   Request channel: drive req_mode and req_node_id with start high; the item is
//   taken at a rising edge where start is high and busy is low. busy rises at
//   acceptance and is high while the cells search and update.
//   Result channel: rsp_valid strobes for exactly one cycle with rsp_status,
//   rsp_result_id, rsp_member_count and rsp_member_map (map and count after the
//   step). The receiver cannot stall; a result is never held back.
//   Config channel: csr_ready is always high; a write with csr_valid loads the
//   controller ID. Write it only while the block is idle.
// Request flow
//   The item is registered at acceptance; in the busy cycle the cells search,
//   then the cells and result registers load, and the result is on the ports
//   in the cycle after that. No item is taken while busy. The find-first of a
//   free or member slot is a flag chain through all HIGHEST_ID+1 cells.
// Reset
//   Synchronous, active high: clears the map, the count, the controller ID and
//   all handshake state. No clearing pass is needed.

module node_id_bitmap_allocator #(
   parameter int unsigned NODE_SLOTS = 64,
   parameter int unsigned LOWEST_ID  = 1,
   parameter int unsigned HIGHEST_ID = 63
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [nba_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [nba_pkg::ID_W-1:0]           req_node_id,
   // result channel
   output logic                                   rsp_valid,
   output logic [nba_pkg::STATUS_W-1:0]           rsp_status,
   output logic [nba_pkg::ID_W-1:0]               rsp_result_id,
   output logic [nba_pkg::COUNT_W-1:0]            rsp_member_count,
   output logic [nba_pkg::MAP_W-1:0]              rsp_member_map,
   // configuration channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [nba_pkg::ID_W-1:0]           csr_controller_id
);

   localparam int unsigned NCELL = HIGHEST_ID + 1;
   localparam logic [nba_pkg::ID_W-1:0]    LOW_ID   = nba_pkg::ID_W'(LOWEST_ID);
   localparam logic [nba_pkg::ID_W-1:0]    HIGH_ID  = nba_pkg::ID_W'(HIGHEST_ID);
   localparam logic [nba_pkg::ID_W-1:0]    PAST_ID  = nba_pkg::ID_W'(HIGHEST_ID + 1);
   localparam logic [nba_pkg::COUNT_W-1:0] SLOTS    = nba_pkg::COUNT_W'(NODE_SLOTS);

   // control and held request
   logic                          busy_ff;
   logic                          busy_in;
   logic [nba_pkg::MODE_W-1:0]    mode_ff;
   logic [nba_pkg::ID_W-1:0]      node_id_ff;
   logic [nba_pkg::ID_W-1:0]      controller_id_ff;
   logic [nba_pkg::COUNT_W-1:0]   total_ff;
   logic [nba_pkg::COUNT_W-1:0]   total_in;

   // result registers
   logic                          rsp_valid_ff;
   logic [nba_pkg::STATUS_W-1:0]  status_ff;
   logic [nba_pkg::STATUS_W-1:0]  status_in;
   logic [nba_pkg::ID_W-1:0]      result_id_ff;
   logic [nba_pkg::ID_W-1:0]      result_id_in;
   logic [nba_pkg::MAP_W-1:0]     map_ff;
   logic [nba_pkg::MAP_W-1:0]     map_in;

   nba_pkg::cell_req_type         cell_req;
   nba_pkg::cell_op_type          cell_op;
   nba_pkg::cell_chain_type       chain [NCELL+1];
   nba_pkg::cell_stat_type        stat  [NCELL];

   logic                          taken;
   logic                          any_free;
   logic                          any_member;
   logic [nba_pkg::ID_W-1:0]      free_id;
   logic [nba_pkg::ID_W-1:0]      member_id;
   logic                          out_of_range;
   logic                          is_controller;

   logic accept;
   assign accept = start && !busy_ff;

   assign cell_req.node_id       = node_id_ff;
   assign cell_req.controller_id = controller_id_ff;
   assign chain[0]               = '0;

   // row of cells, search flags run from ID 0 upward
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      nba_cell #(
         .CELL_ID   (i),
         .LOWEST_ID (LOWEST_ID)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .req       (cell_req),
         .op        (cell_op),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .stat      (stat[i])
      );
      assign map_in[i] = stat[i].bit_next;
   end

   if (NCELL < nba_pkg::MAP_W) begin : g_map_pad
      assign map_in[nba_pkg::MAP_W-1:NCELL] = '0;
   end

   // gather hits; at most one cell hits each search, so OR the indexes
   always_comb begin
      taken     = 1'b0;
      free_id   = '0;
      member_id = '0;
      for (int i = 0; i < NCELL; i++) begin
         taken = taken | stat[i].taken;
         if (stat[i].hit_free) begin
            free_id = free_id | nba_pkg::ID_W'(i);
         end
         if (stat[i].hit_member) begin
            member_id = member_id | nba_pkg::ID_W'(i);
         end
      end
   end

   assign any_free      = chain[NCELL].free_seen;
   assign any_member    = chain[NCELL].member_seen;
   assign out_of_range  = (node_id_ff < LOW_ID) || (node_id_ff > HIGH_ID);
   assign is_controller = (node_id_ff == controller_id_ff);

   // decide the step while busy; hold the cells otherwise
   always_comb begin
      cell_op      = '0;
      status_in    = nba_pkg::ST_OK;
      result_id_in = '0;
      total_in     = total_ff;
      if (busy_ff) begin
         case (mode_ff)
            nba_pkg::MODE_CLEAR: begin
               cell_op.clear_all = 1'b1;
               total_in          = '0;
            end
            nba_pkg::MODE_NEXT: begin
               if (any_member) begin
                  result_id_in = member_id;
               end else begin
                  status_in    = nba_pkg::ST_NONE;
                  result_id_in = PAST_ID;
               end
            end
            nba_pkg::MODE_ADD: begin
               if (total_ff >= SLOTS) begin
                  status_in = nba_pkg::ST_FULL;
               end else if (out_of_range) begin
                  status_in = nba_pkg::ST_RANGE;
               end else if (is_controller) begin
                  status_in = nba_pkg::ST_CTRL;
               end else if (!taken) begin
                  cell_op.set_target = 1'b1;
                  result_id_in       = node_id_ff;
                  total_in           = total_ff + 1'b1;
               end else if (any_free) begin
                  cell_op.set_free = 1'b1;
                  result_id_in     = free_id;
                  total_in         = total_ff + 1'b1;
               end else begin
                  status_in = nba_pkg::ST_FULL;
               end
            end
            nba_pkg::MODE_REMOVE: begin
               if (out_of_range) begin
                  status_in = nba_pkg::ST_RANGE;
               end else if (is_controller) begin
                  status_in = nba_pkg::ST_CTRL;
               end else if (!taken) begin
                  status_in = nba_pkg::ST_NONE;
               end else begin
                  cell_op.clr_target = 1'b1;
                  result_id_in       = node_id_ff;
                  total_in           = total_ff - 1'b1;
               end
            end
            default: begin
               status_in = nba_pkg::ST_OK;
            end
         endcase
      end
   end

   assign busy_in = accept;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         total_ff         <= '0;
         controller_id_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= busy_ff;
         total_ff     <= total_in;
         if (csr_valid) begin
            controller_id_ff <= csr_controller_id;
         end
      end
   end

   // payload: capture the item, then the result of its step
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         node_id_ff <= req_node_id;
      end
      if (busy_ff) begin
         status_ff    <= status_in;
         result_id_ff <= result_id_in;
         map_ff       <= map_in;
      end
   end

   assign busy             = busy_ff;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_id    = result_id_ff;
   assign rsp_member_count = total_ff;
   assign rsp_member_map   = map_ff;

`ifndef ASSERT_OFF
   a_busy_one_cycle : assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("busy held longer than one update cycle");

   a_rsp_follows_busy : assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid_ff)
      else $error("update cycle without a result strobe");

   a_count_matches_map : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones(map_ff) == int'(total_ff)))
      else $error("member count disagrees with bitmap");

   a_single_op : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cell_op.clear_all, cell_op.set_target, cell_op.set_free,
                cell_op.clr_target}))
      else $error("more than one cell operation at once");

   a_no_op_idle : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (cell_op == '0))
      else $error("cells updated outside the update cycle");
`endif

endmodule

`default_nettype wire

>>> tb/sv/node_id_bitmap_allocator_tb.sv
// Self-checking testbench for the node ID bitmap allocator: directed rows, then random traffic.
`timescale 1ns / 1ps

module node_id_bitmap_allocator_tb;

   // Block configuration under test
   localparam int NODE_SLOTS  = 64;
   localparam int LOWEST_ID   = 1;
   localparam int HIGHEST_ID  = 63;
   // Generous ceiling on the run length, in clock cycles
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 225;

   typedef struct packed {
      logic [nba_pkg::STATUS_W-1:0] status;
      logic [nba_pkg::ID_W-1:0]     result_id;
      logic [nba_pkg::COUNT_W-1:0]  member_count;
      logic [nba_pkg::MAP_W-1:0]    member_map;
   } alloc_reply_type;

   typedef struct {
      logic [nba_pkg::MODE_W-1:0] mode;
      logic [nba_pkg::ID_W-1:0]   node_id;
      bit                         typed;
      alloc_reply_type            reply;
   } directed_row_type;

   typedef enum int {SEQ_FILL, SEQ_DRAIN, SEQ_SCAN, SEQ_NOISE, SEQ_CLEAR} seq_kind_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [nba_pkg::MODE_W-1:0]   req_mode;
   logic [nba_pkg::ID_W-1:0]     req_node_id;
   logic                         rsp_valid;
   logic [nba_pkg::STATUS_W-1:0] rsp_status;
   logic [nba_pkg::ID_W-1:0]     rsp_result_id;
   logic [nba_pkg::COUNT_W-1:0]  rsp_member_count;
   logic [nba_pkg::MAP_W-1:0]    rsp_member_map;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [nba_pkg::ID_W-1:0]     csr_controller_id;

   // Shadow copy of the block's state and its register
   logic [nba_pkg::MAP_W-1:0]    shadow_map;
   logic [nba_pkg::COUNT_W-1:0]  shadow_count;
   logic [nba_pkg::ID_W-1:0]     shadow_ctrl_id;

   // Replies predicted for accepted requests, oldest first
   alloc_reply_type     awaited_replies[$];
   directed_row_type    directed_rows[$];

   int                  failures;
   int                  cycle_count;
   int                  burst_left;

   node_id_bitmap_allocator #(
      .NODE_SLOTS (NODE_SLOTS),
      .LOWEST_ID  (LOWEST_ID),
      .HIGHEST_ID (HIGHEST_ID)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_node_id       (req_node_id),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_member_count  (rsp_member_count),
      .rsp_member_map    (rsp_member_map),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_controller_id (csr_controller_id)
   );

   always #5 clock = ~clock;

   // Apply one request to the shadow state and return the reply it must produce.
   function automatic alloc_reply_type alloc_reply(input logic [nba_pkg::MODE_W-1:0] mode,
                                                   input logic [nba_pkg::ID_W-1:0] node_id);
      alloc_reply_type          r;
      logic [nba_pkg::ID_W-1:0] pick;
      bit                       found;
      bit                       in_range;
      r.status    = nba_pkg::ST_OK;
      r.result_id = '0;
      in_range    = (node_id >= LOWEST_ID) && (node_id <= HIGHEST_ID);
      case (mode)
         nba_pkg::MODE_CLEAR: begin
            shadow_map   = '0;
            shadow_count = '0;
         end
         nba_pkg::MODE_NEXT: begin
            r.status    = nba_pkg::ST_NONE;
            r.result_id = nba_pkg::ID_W'(HIGHEST_ID + 1);
            // scan downward so the last hit is the lowest member at or above the start
            for (int i = HIGHEST_ID; i >= 0; i--) begin
               if (i >= int'(node_id) && shadow_map[i]) begin
                  r.status    = nba_pkg::ST_OK;
                  r.result_id = nba_pkg::ID_W'(i);
               end
            end
         end
         default: begin
            if (mode == nba_pkg::MODE_ADD && shadow_count >= NODE_SLOTS) begin
               r.status = nba_pkg::ST_FULL;
            end else if (!in_range) begin
               r.status = nba_pkg::ST_RANGE;
            end else if (node_id == shadow_ctrl_id) begin
               r.status = nba_pkg::ST_CTRL;
            end else if (mode == nba_pkg::MODE_REMOVE) begin
               if (!shadow_map[node_id[5:0]]) begin
                  r.status = nba_pkg::ST_NONE;
               end else begin
                  shadow_map[node_id[5:0]] = 1'b0;
                  shadow_count             = shadow_count - 1'b1;
                  r.result_id              = node_id;
               end
            end else begin
               pick  = node_id;
               found = 1'b1;
               if (shadow_map[node_id[5:0]]) begin
                  // taken: fall back to the lowest free ID that is not the controller
                  found = 1'b0;
                  for (int i = HIGHEST_ID; i >= LOWEST_ID; i--) begin
                     if (nba_pkg::ID_W'(i) != shadow_ctrl_id && !shadow_map[i]) begin
                        pick  = nba_pkg::ID_W'(i);
                        found = 1'b1;
                     end
                  end
               end
               if (!found) begin
                  r.status = nba_pkg::ST_FULL;
               end else begin
                  shadow_map[pick[5:0]] = 1'b1;
                  shadow_count          = shadow_count + 1'b1;
                  r.result_id           = pick;
               end
            end
         end
      endcase
      r.member_count = shadow_count;
      r.member_map   = shadow_map;
      return r;
   endfunction

   // Send one request after an optional gap; predict its reply at the accepting edge.
   // Called and returns at a falling edge; start is left high for the caller to decide.
   task automatic send_request(input logic [nba_pkg::MODE_W-1:0] mode,
                               input logic [nba_pkg::ID_W-1:0] node_id,
                               input bit typed, input alloc_reply_type given);
      alloc_reply_type predicted;
      int              gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(30, 1);
         gap = ($urandom_range(9) == 0) ? $urandom_range(25, 8) : $urandom_range(4, 0);
      end
      burst_left--;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_mode    <= mode;
      req_node_id <= node_id;
      do @(posedge clock); while (busy);
      predicted = alloc_reply(mode, node_id);
      awaited_replies.push_back(typed ? given : predicted);
      @(negedge clock);
   endtask

   // Hold the sender off until every predicted reply has come back.
   task automatic wait_for_replies();
      start <= 1'b0;
      do @(negedge clock); while (awaited_replies.size() != 0);
   endtask

   // Load the controller ID; only ever done with the block idle.
   task automatic write_controller(input logic [nba_pkg::ID_W-1:0] value);
      wait_for_replies();
      // let the update and result cycles of the last item pass
      repeat (3) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_controller_id <= value;
      do @(posedge clock); while (!csr_ready);
      shadow_ctrl_id = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(input logic [nba_pkg::MODE_W-1:0] mode,
                          input logic [nba_pkg::ID_W-1:0] node_id,
                          input bit typed, input logic [nba_pkg::STATUS_W-1:0] status,
                          input logic [nba_pkg::ID_W-1:0] result_id,
                          input logic [nba_pkg::COUNT_W-1:0] count,
                          input logic [nba_pkg::MAP_W-1:0] map);
      directed_row_type row;
      row.mode               = mode;
      row.node_id            = node_id;
      row.typed              = typed;
      row.reply.status       = status;
      row.reply.result_id    = result_id;
      row.reply.member_count = count;
      row.reply.member_map   = map;
      directed_rows.push_back(row);
   endtask

   // Random traffic: mostly runs of one kind of request, so the map really fills and drains.
   task automatic run_random(input int n_items);
      seq_kind_type               kind;
      int                         seq_left;
      int                         pick;
      logic [nba_pkg::MODE_W-1:0] mode;
      logic [nba_pkg::ID_W-1:0]   node_id;
      alloc_reply_type            none;
      none     = '0;
      kind     = SEQ_NOISE;
      seq_left = 0;
      for (int n = 0; n < n_items; n++) begin
         if (seq_left == 0) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               kind = SEQ_FILL;  seq_left = $urandom_range(80, 5);
            end else if (pick < 55) begin
               kind = SEQ_DRAIN; seq_left = $urandom_range(60, 5);
            end else if (pick < 75) begin
               kind = SEQ_SCAN;  seq_left = $urandom_range(20, 2);
            end else if (pick < 95) begin
               kind = SEQ_NOISE; seq_left = $urandom_range(15, 1);
            end else begin
               kind = SEQ_CLEAR; seq_left = 1;
            end
         end
         seq_left--;
         node_id = nba_pkg::ID_W'($urandom_range(HIGHEST_ID, LOWEST_ID));
         case (kind)
            SEQ_FILL: begin
               mode = nba_pkg::MODE_ADD;
               if ($urandom_range(9) == 0) node_id = shadow_ctrl_id;
            end
            SEQ_DRAIN: begin
               mode = nba_pkg::MODE_REMOVE;
               if ($urandom_range(9) == 0) node_id = shadow_ctrl_id;
            end
            SEQ_SCAN: begin
               mode    = nba_pkg::MODE_NEXT;
               node_id = ($urandom_range(7) == 0)
                         ? nba_pkg::ID_W'($urandom_range(255))
                         : nba_pkg::ID_W'($urandom_range(HIGHEST_ID + 2));
            end
            SEQ_CLEAR: begin
               mode    = nba_pkg::MODE_CLEAR;
               node_id = nba_pkg::ID_W'($urandom_range(255));
            end
            default: begin
               mode    = nba_pkg::MODE_W'($urandom_range(3));
               node_id = nba_pkg::ID_W'($urandom_range(255));
            end
         endcase
         // now and then drain the pipe completely before going on
         if ($urandom_range(149) == 0) wait_for_replies();
         send_request(mode, node_id, 1'b0, none);
      end
   endtask

   // Compare every strobed reply with the oldest prediction.
   always @(posedge clock) begin
      alloc_reply_type want;
      if (!reset && rsp_valid) begin
         if (awaited_replies.size() == 0) begin
            $error("unexpected reply: status %0d result_id %0d", rsp_status, rsp_result_id);
            failures++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_result_id !== want.result_id) begin
               $error("result_id: expected %0d, actual %0d", want.result_id, rsp_result_id);
               failures++;
            end
            if (rsp_member_count !== want.member_count) begin
               $error("member_count: expected %0d, actual %0d",
                      want.member_count, rsp_member_count);
               failures++;
            end
            if (rsp_member_map !== want.member_map) begin
               $error("member_map: expected %h, actual %h", want.member_map, rsp_member_map);
               failures++;
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      // Drive every input to a known value from time zero
      clock             = 1'b0;
      reset             = 1'b1;
      start             = 1'b0;
      req_mode          = nba_pkg::MODE_ADD;
      req_node_id       = '0;
      csr_valid         = 1'b0;
      csr_controller_id = '0;
      failures          = 0;
      cycle_count       = 0;
      burst_left        = 0;
      shadow_map        = '0;
      shadow_count      = '0;
      shadow_ctrl_id    = '0;

      // Directed rows; the controller sits at 10 so the controller check is reachable.
      // Rows marked typed carry their reply written out; the rest use the predictor.
      add_row(nba_pkg::MODE_NEXT,   8'd0,   1'b1, nba_pkg::ST_NONE,  8'd64, 7'd0, 64'd0);
      add_row(nba_pkg::MODE_REMOVE, 8'd5,   1'b1, nba_pkg::ST_NONE,  8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_ADD,    8'd0,   1'b1, nba_pkg::ST_RANGE, 8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_ADD,    8'd64,  1'b1, nba_pkg::ST_RANGE, 8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_ADD,    8'd255, 1'b1, nba_pkg::ST_RANGE, 8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_REMOVE, 8'd255, 1'b1, nba_pkg::ST_RANGE, 8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_ADD,    8'd10,  1'b1, nba_pkg::ST_CTRL,  8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_REMOVE, 8'd10,  1'b1, nba_pkg::ST_CTRL,  8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_ADD,    8'd1,   1'b1, nba_pkg::ST_OK,    8'd1,  7'd1, 64'h2);
      add_row(nba_pkg::MODE_ADD,    8'd63,  1'b1, nba_pkg::ST_OK,    8'd63, 7'd2,
              64'h8000_0000_0000_0002);
      // taken IDs fall back to the lowest free one
      add_row(nba_pkg::MODE_ADD,    8'd63,  1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_ADD,    8'd2,   1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_NEXT,   8'd0,   1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_NEXT,   8'd4,   1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_NEXT,   8'd63,  1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_NEXT,   8'd64,  1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_NEXT,   8'd255, 1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_REMOVE, 8'd63,  1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_REMOVE, 8'd63,  1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_ADD,    8'd9,   1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_ADD,    8'd11,  1'b0, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_CLEAR,  8'd0,   1'b1, nba_pkg::ST_OK,    8'd0,  7'd0, 64'd0);
      add_row(nba_pkg::MODE_NEXT,   8'd1,   1'b1, nba_pkg::ST_NONE,  8'd64, 7'd0, 64'd0);

      // Hold reset, release at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_controller(8'd10);
      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].mode, directed_rows[r].node_id,
                      directed_rows[r].typed, directed_rows[r].reply);
      end

      // Random phases: controller outside the range, at both ends, at zero, inside, then anywhere.
      // State carries over between phases, so a new controller may already be a member.
      write_controller(8'd255);
      run_random(PHASE_ITEMS);
      write_controller(nba_pkg::ID_W'(HIGHEST_ID));
      run_random(PHASE_ITEMS);
      write_controller(nba_pkg::ID_W'(LOWEST_ID));
      run_random(PHASE_ITEMS);
      write_controller(8'd0);
      run_random(PHASE_ITEMS);
      write_controller(nba_pkg::ID_W'($urandom_range(HIGHEST_ID - 1, LOWEST_ID + 1)));
      run_random(PHASE_ITEMS);
      write_controller(nba_pkg::ID_W'($urandom_range(255)));
      run_random(PHASE_ITEMS);

      // Drain and let the pipeline settle before the verdict
      wait_for_replies();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
